// ----- rtl/nnpp_pkg.sv -----
// nnpp_pkg: shared widths, register indexes and beat types for the
// nearest non-black pixel pick block; no dependencies
package nnpp_pkg;

  localparam int BOX_SIZE_DEFAULT = 11;

  localparam int COLOR_W  = 24;
  localparam int INDEX_W  = 25;
  localparam int COORD_W  = 14;
  localparam int EXTENT_W = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_PICK_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd3;

  // pixel beat as held in the input stage
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } pix_t;

  // viewport setup handed to the selection stage
  typedef struct packed {
    logic [COORD_W-1:0]  pick_x;
    logic [COORD_W-1:0]  pick_y;
    logic [EXTENT_W-1:0] view_width;
    logic [EXTENT_W-1:0] view_height;
  } view_t;

endpackage

// ----- rtl/nnpp_if.sv -----
// nnpp channel interfaces: pixel input, index result and register writes
// depends on nnpp_pkg
interface nnpp_pix_if
  import nnpp_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface nnpp_res_if
  import nnpp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [INDEX_W-1:0] selected_index;

  modport source (output valid, selected_index, input ready);
  modport sink   (input valid, selected_index, output ready);
endinterface

interface nnpp_cfg_if
  import nnpp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/nnpp_scan.sv -----
// nnpp_scan: input stage register and box column/row counters
// depends on nnpp_pkg
module nnpp_scan
  import nnpp_pkg::*;
#(
  parameter int BOX_SIZE = BOX_SIZE_DEFAULT,
  localparam int CNT_W = $clog2(BOX_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pix_t             in_pix,
  input  logic             stage_take,
  output logic             stage_valid,
  output pix_t             stage_pix,
  output logic [CNT_W-1:0] stage_col,
  output logic [CNT_W-1:0] stage_row
);

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(BOX_SIZE - 1);

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic             accept;

  assign in_ready = !stage_valid || stage_take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_take) begin
        stage_valid <= 1'b0;
      end
      if (accept) begin
        if (in_pix.last) begin
          column_count <= '0;
          row_count    <= '0;
        end else if (column_count == LAST_POS) begin
          column_count <= '0;
          // overlong box wraps back to the first row
          row_count    <= (row_count == LAST_POS) ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_pix <= in_pix;
      stage_col <= column_count;
      stage_row <= row_count;
    end
  end

endmodule

// ----- rtl/nnpp_select.sv -----
// nnpp_select: viewport test, ring distance compare, best-so-far state and
// the result register; depends on nnpp_pkg
module nnpp_select
  import nnpp_pkg::*;
#(
  parameter int BOX_SIZE = BOX_SIZE_DEFAULT,
  localparam int CNT_W  = $clog2(BOX_SIZE),
  localparam int HALF   = BOX_SIZE / 2,
  localparam int DIST_W = $clog2(HALF + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  view_t                     view,
  input  logic                      stage_valid,
  input  pix_t                      stage_pix,
  input  logic [CNT_W-1:0]          stage_col,
  input  logic [CNT_W-1:0]          stage_row,
  output logic                      stage_take,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [INDEX_W-1:0] out_index
);

  localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF);
  localparam logic [15:0]      HALF_16  = 16'(HALF);

  logic              have_candidate;
  logic [DIST_W-1:0] best_distance;
  logic [CNT_W-1:0]  best_column;
  logic [CNT_W-1:0]  best_row;
  logic [COLOR_W-1:0] best_color;

  logic               have_next;
  logic [COLOR_W-1:0] color_next;
  logic [15:0]        sum_x, sum_y;
  logic               in_view, qualify, better, update;
  logic [CNT_W-1:0]   dx, dy;
  logic [DIST_W-1:0]  ring_dist;

  assign stage_take = stage_valid && (!stage_pix.last || !out_valid || out_ready);

  always_comb begin
    // box position to frame coordinate, kept unsigned by testing against half first
    sum_x  = 16'(view.pick_x) + 16'(stage_col);
    sum_y  = 16'(view.pick_y) + 16'(stage_row);
    in_view = (sum_x >= HALF_16) && ((sum_x - HALF_16) < 16'(view.view_width)) &&
              (sum_y >= HALF_16) && ((sum_y - HALF_16) < 16'(view.view_height));
    qualify = in_view && (stage_pix.color != '0);
    dx = (stage_col >= HALF_CNT) ? stage_col - HALF_CNT : HALF_CNT - stage_col;
    dy = (stage_row >= HALF_CNT) ? stage_row - HALF_CNT : HALF_CNT - stage_row;
    ring_dist = (dx > dy) ? DIST_W'(dx) : DIST_W'(dy);
    better = !have_candidate || (ring_dist < best_distance) ||
             ((ring_dist == best_distance) &&
              ((stage_col < best_column) ||
               ((stage_col == best_column) && (stage_row < best_row))));
    update     = stage_take && qualify && better;
    have_next  = have_candidate || (qualify && better);
    color_next = (qualify && better) ? stage_pix.color : best_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_candidate <= 1'b0;
      best_distance  <= '0;
      best_column    <= '0;
      best_row       <= '0;
      best_color     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (stage_take && stage_pix.last) begin
        have_candidate <= 1'b0;
        best_distance  <= '0;
        best_column    <= '0;
        best_row       <= '0;
        best_color     <= '0;
      end else if (update) begin
        have_candidate <= 1'b1;
        best_distance  <= ring_dist;
        best_column    <= stage_col;
        best_row       <= stage_row;
        best_color     <= stage_pix.color;
      end
      if (stage_take && stage_pix.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && stage_pix.last) begin
      // id is the color minus one, all ones when nothing qualified
      out_index <= have_next ? $signed({1'b0, color_next - 1'b1}) : '1;
    end
  end

endmodule

// ----- rtl/nearest_nonblack_pixel_pick.sv -----
// nearest_nonblack_pixel_pick: top level, register file and stage wiring
// depends on nnpp_pkg, nnpp_if, nnpp_scan, nnpp_select
// path: the last pixel beat passes the input stage, then the output register
// throughput: one pixel beat per cycle; the input stage stalls only when a
//   last pixel meets an untaken result in the output register
// reset: rst (synchronous) clears the counters, the stage valid, the best
//   candidate, the output valid and the viewport registers to zero
module nearest_nonblack_pixel_pick
  import nnpp_pkg::*;
#(
  parameter int BOX_SIZE = BOX_SIZE_DEFAULT,
  localparam int CNT_W = $clog2(BOX_SIZE)
) (
  input logic        clk,
  input logic        rst,
  nnpp_pix_if.sink   pix,
  nnpp_res_if.source res,
  nnpp_cfg_if.sink   cfg
);

  view_t            view;
  pix_t             in_pix;
  pix_t             stage_pix;
  logic             stage_valid;
  logic             stage_take;
  logic [CNT_W-1:0] stage_col;
  logic [CNT_W-1:0] stage_row;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PICK_X:      view.pick_x      <= cfg.data[COORD_W-1:0];
        REG_PICK_Y:      view.pick_y      <= cfg.data[COORD_W-1:0];
        REG_VIEW_WIDTH:  view.view_width  <= cfg.data[EXTENT_W-1:0];
        REG_VIEW_HEIGHT: view.view_height <= cfg.data[EXTENT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix.color = {pix.blue, pix.green, pix.red};
  assign in_pix.last  = pix.last_pixel;

  nnpp_scan #(
    .BOX_SIZE (BOX_SIZE)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pix.valid),
    .in_ready    (pix.ready),
    .in_pix      (in_pix),
    .stage_take  (stage_take),
    .stage_valid (stage_valid),
    .stage_pix   (stage_pix),
    .stage_col   (stage_col),
    .stage_row   (stage_row)
  );

  nnpp_select #(
    .BOX_SIZE (BOX_SIZE)
  ) u_select (
    .clk         (clk),
    .rst         (rst),
    .view        (view),
    .stage_valid (stage_valid),
    .stage_pix   (stage_pix),
    .stage_col   (stage_col),
    .stage_row   (stage_row),
    .stage_take  (stage_take),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_index   (res.selected_index)
  );

endmodule
